// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/ncri_pkg.sv =====
// Package with shared constants and types of the cubic Newton iterator.
package ncri_pkg;
    localparam int MaxSteps = 64;
    localparam int FracBits = 16;
    localparam int W = 32;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO_DERIV = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;
    localparam logic [1:0] REG_CUBIC = 2'd0;
    localparam logic [1:0] REG_SQUARE = 2'd1;
    localparam logic [1:0] REG_LINEAR = 2'd2;
    localparam logic [1:0] REG_CONST = 2'd3;

    typedef struct packed {
        logic start;
        logic done;
    } t_hs;
endpackage

// ===== hw/rtl/ncri_mul.sv =====
// Bit-serial signed multiplier with rounding shift and 32-bit saturation.
module ncri_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ncri_pkg::t_hs         i_go,
    input  logic signed [31:0]    i_a,
    input  logic signed [31:0]    i_b,
    output ncri_pkg::t_hs         o_hs,
    output logic signed [31:0]    o_p,
    output logic                  o_sat
);
    import ncri_pkg::*;
    // Shift-add over the 32 bits of |b|; one adder of 64 bits per cycle.
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_mc;
    logic [31:0] r_mp;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg, r_done;
    logic signed [65:0] s_prod, s_w, s_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_mc   <= {32'd0, i_a[31] ? 32'(-i_a) : 32'(i_a)};
                r_mp   <= i_b[31] ? 32'(-i_b) : 32'(i_b);
                r_neg  <= i_a[31] ^ i_b[31];
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_mc  <= r_mc << 1;
                r_mp  <= r_mp >> 1;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign n_acc = r_mp[0] ? r_acc + r_mc : r_acc;

    always_comb begin
        s_prod = r_neg ? -$signed({2'b00, r_acc}) : $signed({2'b00, r_acc});
        s_w    = s_prod + 66'sd2 ** (FRAC_BITS - 1);
        s_q    = s_w >>> FRAC_BITS;
        o_sat  = 1'b0;
        if (s_q > 66'sd2147483647) begin
            o_p = 32'h7fffffff; o_sat = 1'b1;
        end else if (s_q < -66'sd2147483648) begin
            o_p = 32'h80000000; o_sat = 1'b1;
        end else begin
            o_p = s_q[31:0];
        end
    end
    assign o_hs.start = r_busy;
    assign o_hs.done  = r_done;

    `include "assert_macros.svh"
    `ASSERT_NEXT(a_mul_busy, i_clk, i_rst_n, i_go.start, r_busy, "multiplier did not start")
    `ASSERT_IMPL(a_mul_excl, i_clk, i_rst_n, r_done, !r_busy, "done while busy")
endmodule

// ===== hw/rtl/ncri_div.sv =====
// Restoring bit-serial divider: (n * 2^FRAC_BITS) / d, truncated, saturated.
module ncri_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ncri_pkg::t_hs         i_go,
    input  logic signed [31:0]    i_n,
    input  logic signed [31:0]    i_d,
    output ncri_pkg::t_hs         o_hs,
    output logic signed [31:0]    o_q,
    output logic                  o_sat
);
    import ncri_pkg::*;
    localparam int NW = 32 + FRAC_BITS;
    logic [NW-1:0] r_num, r_quo;
    logic [32:0]   r_rem;
    logic [31:0]   r_den;
    logic [6:0]    r_cnt;
    logic          r_busy, r_done, r_neg;
    logic [33:0]   s_trial;
    logic [NW:0]   s_sq;

    assign s_trial = {r_rem, r_num[NW-1]} - {2'b00, r_den};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= '0;
                r_num  <= {(i_n[31] ? 32'(-i_n) : 32'(i_n)), {FRAC_BITS{1'b0}}};
                r_den  <= i_d[31] ? 32'(-i_d) : 32'(i_d);
                r_neg  <= i_n[31] ^ i_d[31];
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (!s_trial[33]) begin
                    r_rem <= s_trial[32:0];
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[31:0], r_num[NW-1]};
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    always_comb begin
        s_sq  = r_neg ? (NW+1)'(-{1'b0, r_quo}) : {1'b0, r_quo};
        o_sat = 1'b0;
        o_q   = s_sq[31:0];
        if (!r_neg && r_quo > NW'(32'h7fffffff)) begin
            o_q = 32'h7fffffff; o_sat = 1'b1;
        end else if (r_neg && r_quo > NW'(33'h80000000)) begin
            o_q = 32'h80000000; o_sat = 1'b1;
        end
    end
    assign o_hs.start = r_busy;
    assign o_hs.done  = r_done;

    `include "assert_macros.svh"
    `ASSERT_NEXT(a_div_busy, i_clk, i_rst_n, i_go.start, r_busy, "divider did not start")
endmodule

// ===== hw/rtl/newton_cubic_root_iterator_core.sv =====
// Top level of the cubic Newton iterator: sequencer, registers, output stage.
// Each Newton step takes five serial multiplies (each an issue, a pass
// through the shift-add unit and an accumulate), one serial division, and a
// check and an update, plus output stalls; the first step adds three
// multiplies for the start residual. A step that meets a zero derivative
// stops before the division. The shared shift-add multiplier sets most of
// the run time. One item is worked at a time.
module newton_cubic_root_iterator_core #(
    parameter int MAX_STEPS = ncri_pkg::MaxSteps,
    parameter int FRAC_BITS = ncri_pkg::FracBits
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_start_point,
    input  logic [6:0]         i_iteration_count,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_estimate,
    output logic signed [31:0] o_residual,
    output logic [5:0]         o_step_index,
    output logic               o_last_result,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import ncri_pkg::*;
    localparam int LIM = (MAX_STEPS < 64) ? MAX_STEPS : 64;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL   = 10'b0000000010,
        S_MWAIT = 10'b0000000100,
        S_ADD   = 10'b0000001000,
        S_CHK   = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_DWAIT = 10'b0001000000,
        S_SUB   = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    logic signed [31:0] r_c3, r_c2, r_c1, r_c0;
    logic signed [31:0] r_x, r_px, r_d, r_t, r_ma, r_mb;
    logic [2:0]  r_op;    // micro-op index within the evaluation program
    logic        r_prog;  // 0: poly(x) -> px, 1: deriv(x) -> d
    logic        r_sat, r_first;
    logic [6:0]  r_n, r_k;
    t_hs s_mgo, s_mhs, s_dgo, s_dhs;
    logic signed [31:0] s_mp, s_dq;
    logic s_msat, s_dsat;
    logic signed [33:0] s_sum;
    logic signed [31:0] s_addend;
    logic [6:0] s_n;

    ncri_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk, .i_rst_n, .i_go(s_mgo), .i_a(r_ma), .i_b(r_mb),
        .o_hs(s_mhs), .o_p(s_mp), .o_sat(s_msat));
    ncri_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk, .i_rst_n, .i_go(s_dgo), .i_n(r_px), .i_d(r_d),
        .o_hs(s_dhs), .o_q(s_dq), .o_sat(s_dsat));

    assign s_mgo = '{start: (r_state == S_MUL), done: 1'b0};
    assign s_dgo = '{start: (r_state == S_DIV), done: 1'b0};
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        s_n = (i_iteration_count == 7'd0) ? 7'd1 : i_iteration_count;
        if (s_n > 7'(LIM)) s_n = 7'(LIM);
        // Poly adds c2, c1, c0; deriv adds 2*c2, then c1.
        if (r_prog) s_addend = (r_op == 3'd0) ? 32'(r_c2 <<< 1) : r_c1;
        else unique case (r_op)
            3'd0: s_addend = r_c2;
            3'd1: s_addend = r_c1;
            default: s_addend = r_c0;
        endcase
        if (r_prog && r_op == 3'd0)
            s_sum = 34'(r_t) + {{2{r_c2[31]}}, r_c2} + {{2{r_c2[31]}}, r_c2};
        else
            s_sum = 34'(r_t) + 34'(s_addend);
    end

    // Saturation helper for the 34-bit sums.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v,
                                                 output logic s);
        s = 1'b1;
        if (v > 34'sd2147483647) return 32'h7fffffff;
        if (v < -34'sd2147483648) return 32'h80000000;
        s = 1'b0;
        return v[31:0];
    endfunction

    logic signed [33:0] s_c3x3, s_xq;
    logic signed [31:0] s_sat_sum, s_sat_c3, s_sat_x;
    logic s_f1, s_f2, s_f3;
    always_comb begin
        s_c3x3    = 34'(r_c3) + 34'(r_c3) + 34'(r_c3);
        s_xq      = 34'(r_x) - 34'(s_dq);
        s_sat_sum = sat34(s_sum, s_f1);
        s_sat_c3  = sat34(s_c3x3, s_f2);
        s_sat_x   = sat34(s_xq, s_f3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_c3 <= 32'sd65536; r_c2 <= '0; r_c1 <= '0; r_c0 <= -32'sd1310720;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CUBIC:  r_c3 <= i_cfg_data;
                    REG_SQUARE: r_c2 <= i_cfg_data;
                    REG_LINEAR: r_c1 <= i_cfg_data;
                    REG_CONST:  r_c0 <= i_cfg_data;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_x <= i_start_point; r_n <= s_n; r_k <= '0;
                    r_sat <= 1'b0; r_first <= 1'b1;
                    r_prog <= 1'b0; r_op <= '0;
                    r_ma <= r_c3; r_mb <= i_start_point;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_MWAIT;
                S_MWAIT: if (s_mhs.done) begin
                    r_t <= s_mp; r_sat <= r_sat | s_msat;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (!r_prog && r_op == 3'd2) begin
                        r_px <= s_sat_sum;
                        if (r_first) begin
                            r_first <= 1'b0;
                            r_prog <= 1'b1; r_op <= '0;
                            r_ma <= s_sat_c3; r_mb <= r_x;
                            r_sat <= r_sat | s_f1 | s_f2;
                            r_state <= S_MUL;
                        end else begin
                            r_sat <= r_sat | s_f1;
                            r_state <= S_EMIT;
                        end
                    end else if (r_prog && r_op == 3'd1) begin
                        r_d <= s_sat_sum;
                        r_sat <= r_sat | s_f1;
                        r_state <= S_CHK;
                    end else begin
                        r_op <= r_op + 3'd1;
                        r_ma <= s_sat_sum; r_mb <= r_x;
                        r_sat <= r_sat | s_f1;
                        r_state <= S_MUL;
                    end
                end
                S_CHK: r_state <= (r_d == 32'sd0) ? S_OUT : S_DIV;
                S_DIV: r_state <= S_DWAIT;
                S_DWAIT: if (s_dhs.done) begin
                    r_t <= s_dq; r_sat <= r_sat | s_dsat;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_x <= s_sat_x; r_sat <= r_sat | s_f3;
                    r_prog <= 1'b0; r_op <= '0;
                    r_ma <= r_c3; r_mb <= s_sat_x;
                    r_state <= S_MUL;
                end
                S_EMIT: r_state <= S_OUT;
                S_OUT: if (!i_stall) begin
                    if (o_last_result) r_state <= S_IDLE;
                    else begin
                        r_k <= r_k + 7'd1;
                        r_prog <= 1'b1; r_op <= '0;
                        r_ma <= s_sat_c3; r_mb <= r_x;
                        r_sat <= r_sat | s_f2;
                        r_state <= S_MUL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // In S_OUT a zero derivative is recognized by r_d, since a finished
    // division step always leaves a nonzero divisor there.
    logic s_zd;
    assign s_zd = (r_d == 32'sd0);
    assign o_estimate    = r_x;
    assign o_residual    = r_px;
    assign o_step_index  = r_k[5:0];
    assign o_last_result = s_zd || (r_k + 7'd1 == r_n);
    assign o_status      = s_zd ? ST_ZERO_DERIV : (r_sat ? ST_SAT : ST_OK);

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_out_idle, i_clk, i_rst_n, o_valid, !(r_state == S_IDLE), "valid in idle")
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_estimate),
                 "stalled beat changed")
    `ASSERT_IMPL(a_step_range, i_clk, i_rst_n, o_valid, r_k < r_n, "step index past count")
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the cubic Newton root iterator core.
`timescale 1ns / 100ps

module tb_top;
    import ncri_pkg::*;

    typedef struct {
        logic signed [31:0] start_point;
        logic [6:0]         count;
    } t_run_req;

    typedef struct {
        logic signed [31:0] estimate;
        logic signed [31:0] residual;
        logic [5:0]         step_index;
        logic               last_result;
        logic [1:0]         status;
    } t_step_res;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam int WATCHDOG_LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_start_point;
    logic [6:0]         i_iteration_count;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_estimate;
    logic signed [31:0] o_residual;
    logic [5:0]         o_step_index;
    logic               o_last_result;
    logic [1:0]         o_status;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    newton_cubic_root_iterator_core i_dut (.*);

    longint    coef_q[4];
    t_run_req  run_queue[$];
    t_step_res step_queue[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_sender;
    int        error_count;
    int        quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint clip32(longint v, ref bit sat);
        if (v > S32_MAX) begin
            sat = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            sat = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    // Round half up, then saturate; the arithmetic shift is a floor.
    function automatic longint qmul(longint a, longint b, ref bit sat);
        longint p;
        p = (a * b + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
        return clip32(p, sat);
    endfunction

    function automatic longint eval_cubic(longint x, ref bit sat);
        longint t;
        t = clip32(qmul(coef_q[REG_CUBIC], x, sat) + coef_q[REG_SQUARE], sat);
        t = clip32(qmul(t, x, sat) + coef_q[REG_LINEAR], sat);
        return clip32(qmul(t, x, sat) + coef_q[REG_CONST], sat);
    endfunction

    function automatic longint eval_slope(longint x, ref bit sat);
        longint t;
        t = clip32(3 * coef_q[REG_CUBIC], sat);
        t = clip32(qmul(t, x, sat) + 2 * coef_q[REG_SQUARE], sat);
        return clip32(qmul(t, x, sat) + coef_q[REG_LINEAR], sat);
    endfunction

    task automatic predict_iterates(t_run_req req);
        longint    x;
        longint    px;
        longint    d;
        longint    q;
        int        n;
        bit        sat;
        t_step_res r;
        sat = 1'b0;
        x = req.start_point;
        n = req.count;
        if (n == 0) n = 1;
        if (n > MaxSteps) n = MaxSteps;
        px = eval_cubic(x, sat);
        for (int k = 0; k < n; k++) begin
            d = eval_slope(x, sat);
            if (d == 0) begin
                r.status = ST_ZERO_DERIV;
                r.last_result = 1'b1;
            end else begin
                // SystemVerilog division truncates toward zero.
                q = clip32((px * (64'sd1 <<< FracBits)) / d, sat);
                x = clip32(x - q, sat);
                px = eval_cubic(x, sat);
                r.status = sat ? ST_SAT : ST_OK;
                r.last_result = (k + 1 == n);
            end
            r.estimate = x[31:0];
            r.residual = px[31:0];
            r.step_index = k[5:0];
            step_queue.push_back(r);
            if (r.last_result) break;
        end
    endtask

    // Driver: one beat per accepted request; valid stays high across back-to-back beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_iterates('{i_start_point, i_iteration_count});
            end
            if ((!i_valid || !o_stall) ) begin
                if (run_queue.size() != 0 && !hold_sender
                        && $urandom_range(99) >= send_idle_pct) begin
                    i_start_point <= run_queue[0].start_point;
                    i_iteration_count <= run_queue[0].count;
                    i_valid <= 1'b1;
                    void'(run_queue.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_step_res e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (o_valid && !i_stall) begin
                if (step_queue.size() == 0) begin
                    $display("%0t: unexpected result beat est=%0d res=%0d", $time,
                        o_estimate, o_residual);
                    error_count++;
                end else begin
                    e = step_queue.pop_front();
                    if (o_estimate !== e.estimate || o_residual !== e.residual
                            || o_step_index !== e.step_index
                            || o_last_result !== e.last_result
                            || o_status !== e.status) begin
                        $display("%0t: mismatch expected est=%0d res=%0d idx=%0d last=%0b st=%0d",
                            $time, e.estimate, e.residual, e.step_index, e.last_result,
                            e.status);
                        $display("%0t:          actual est=%0d res=%0d idx=%0d last=%0b st=%0d",
                            $time, o_estimate, o_residual, o_step_index, o_last_result,
                            o_status);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_coef(logic [1:0] idx, longint v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v[31:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        coef_q[idx] = longint'(signed'(v[31:0]));
    endtask

    task automatic set_cubic(longint c3, longint c2, longint c1, longint c0);
        write_coef(REG_CUBIC, c3);
        write_coef(REG_SQUARE, c2);
        write_coef(REG_LINEAR, c1);
        write_coef(REG_CONST, c0);
    endtask

    task automatic queue_run(logic [31:0] sp, logic [6:0] n);
        run_queue.push_back('{sp, n});
    endtask

    // Waits until every request is sent and every result has come back.
    task automatic drain;
        while (run_queue.size() != 0 || i_valid || step_queue.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
            2: return 32'($signed($urandom_range(1 << 16)) - (1 << 15));
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_point();
        case ($urandom_range(3))
            0: return $urandom;
            default: return 32'($signed($urandom_range(16 << 16)) - (8 << 16));
        endcase
    endfunction

    function automatic logic [6:0] rand_count();
        case ($urandom_range(9))
            0: return 7'($urandom);
            1: return 7'd64;
            default: return 7'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_start_point = '0;
        i_iteration_count = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_CUBIC;
        i_cfg_data = '0;
        hold_sender = 1'b0;
        error_count = 0;
        send_idle_pct = 22;
        recv_idle_pct = 88;
        coef_q[REG_CUBIC] = 65536;
        coef_q[REG_SQUARE] = 0;
        coef_q[REG_LINEAR] = 0;
        coef_q[REG_CONST] = -1310720;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the reset cubic x^3 - 20.
        queue_run(32'h0003_0000, 7'd6);
        queue_run(32'h0000_0000, 7'd3);       // zero slope at the origin
        queue_run(32'h7FFF_FFFF, 7'd4);
        queue_run(32'h8000_0000, 7'd4);
        queue_run(32'hFFFF_FFFF, 7'd2);
        queue_run(32'h0001_0000, 7'd0);       // a count of zero acts as one
        queue_run(32'h0002_0000, 7'd127);     // capped at the step limit
        queue_run(32'h0002_8000, 7'd64);
        queue_run(32'hFFFE_0000, 7'd1);
        drain();

        // Extreme coefficients.
        set_cubic(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_run(32'h0001_0000, 7'd5);
        queue_run(32'h5555_5555, 7'd3);
        queue_run(32'hAAAA_AAAA, 7'd3);
        drain();
        set_cubic(0, 0, 0, 32'h0001_0000);    // constant: zero slope on the first step
        queue_run(32'h1234_5678, 7'd8);
        drain();
        set_cubic(0, 0, 32'h0002_0000, 32'hFFFF_0000);
        queue_run(32'h0010_0000, 7'd4);
        queue_run(32'h8000_0000, 7'd2);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 88 : 0;
            recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 22 : 0;
            for (int s = 0; s < 4; s++) begin
                set_cubic(rand_coef(), rand_coef(), rand_coef(), rand_coef());
                for (int j = 0; j < 17; j++) queue_run(rand_point(), rand_count());
                // Hold the sender back until the results so far have all come.
                if (s == 1) begin
                    while (run_queue.size() > 8) @(posedge i_clk);
                    hold_sender = 1'b1;
                    while (i_valid || step_queue.size() != 0) @(posedge i_clk);
                    hold_sender = 1'b0;
                end
                drain();
            end
        end

        if (error_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
